// File: design/hci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hci_pkg;

  localparam int FRACTION_BITS = 16;

  // full position in the Q1.16 input scale
  localparam logic [16:0] POS_FULL = 17'd65536;

  // twice the largest channel value: lightness divisor
  localparam int L_DEN = 510;

  // divider operand width: six times a channel difference fits
  localparam int DIV_W = 11;

  typedef struct packed {
    logic [7:0]  start_red;
    logic [7:0]  start_green;
    logic [7:0]  start_blue;
    logic [7:0]  end_red;
    logic [7:0]  end_green;
    logic [7:0]  end_blue;
    logic [16:0] position;
  } pair_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } color_t;

endpackage
`default_nettype wire

// File: design/hci_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per stage: q = floor(x * 2^(QW-1) / den),
// valid for x <= den and den != 0.
module hci_div #(
  parameter int DW = hci_pkg::DIV_W,
  parameter int QW = hci_pkg::FRACTION_BITS + 1
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] x,
  input  wire logic [DW-1:0] den,
  output logic      [QW-1:0] q
);

  logic [DW-1:0] rem   [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [DW:0]   rin;
    logic [DW-1:0] dn;
    logic          qb;
    logic [QW-1:0] qn;

    if (s == 0) begin : g_first
      assign rin = {1'b0, x};
      assign dn  = den;
      assign qn  = QW'(qb);
    end else begin : g_next
      assign rin = {rem[s-1], 1'b0};
      assign dn  = den_r[s-1];
      assign qn  = {q_r[s-1][QW-2:0], qb};
    end

    assign qb = (rin >= {1'b0, dn});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]   <= qb ? DW'(rin - {1'b0, dn}) : DW'(rin);
        den_r[s] <= dn;
        q_r[s]   <= qn;
      end
    end
  end

  assign q = q_r[QW-1];

endmodule
`default_nettype wire

// File: design/hci_to_hsl.sv
`timescale 1ns / 1ps
`default_nettype none
module hci_to_hsl #(
  parameter int FB = hci_pkg::FRACTION_BITS
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  output logic      [FB:0] hue,
  output logic      [FB:0] sat,
  output logic      [FB:0] light
);

  localparam int DW = hci_pkg::DIV_W;

  // lightness = floor(sum * 2^FB / 510) = floor(sum * L_MUL / 2^17),
  // exact for every sum up to 510
  localparam int LMW = FB + 9;
  localparam logic [LMW-1:0] L_MUL = LMW'(((64'd1 << (FB + 16)) + 64'd254) / 64'd255);

  logic [7:0] r_a, g_a, b_a, hi_a, lo_a;
  logic [7:0] hi_c, lo_c;

  always_comb begin
    hi_c = red;
    lo_c = red;
    if (green > hi_c) hi_c = green;
    if (blue > hi_c)  hi_c = blue;
    if (green < lo_c) lo_c = green;
    if (blue < lo_c)  lo_c = blue;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_a  <= red;
      g_a  <= green;
      b_a  <= blue;
      hi_a <= hi_c;
      lo_a <= lo_c;
    end
  end

  logic [8:0]    sum;
  logic [DW-1:0] d, six_d, t, xs_c, ds_c, xh_c, dh_c;
  logic [DW-1:0] xs, ds, xh, dh;
  logic [LMW+8:0] lprod;
  logic [FB:0]    lb;
  logic [FB:0]    light_d [FB + 1];

  always_comb begin
    sum   = {1'b0, hi_a} + {1'b0, lo_a};
    d     = DW'(hi_a - lo_a);
    six_d = DW'((d << 2) + (d << 1));
    priority if (hi_a == r_a) begin
      if (g_a >= b_a) t = DW'(g_a - b_a);
      else            t = six_d - DW'(b_a - g_a);
    end else if (hi_a == g_a) begin
      t = DW'(d << 1) + DW'(b_a) - DW'(r_a);
    end else begin
      t = DW'(d << 2) + DW'(r_a) - DW'(g_a);
    end
    if (hi_a == lo_a) begin
      // gray: force hue and saturation to zero
      xs_c = '0;
      ds_c = DW'(1);
      xh_c = '0;
      dh_c = DW'(1);
    end else begin
      xs_c = d;
      ds_c = (sum > 9'd255) ? DW'(10'(hci_pkg::L_DEN) - {1'b0, sum}) : DW'(sum);
      xh_c = t;
      dh_c = six_d;
    end
  end

  assign lprod = sum * L_MUL;

  always_ff @(posedge clk) begin
    if (en) begin
      xs <= xs_c;
      ds <= ds_c;
      xh <= xh_c;
      dh <= dh_c;
      lb <= lprod[17 +: FB + 1];
    end
  end

  // delay lightness to line up with the divider outputs
  always_ff @(posedge clk) begin
    if (en) begin
      light_d[0] <= lb;
      for (int i = 1; i < FB + 1; i++) light_d[i] <= light_d[i-1];
    end
  end

  assign light = light_d[FB];

  hci_div #(.DW(DW), .QW(FB + 1)) u_div_h (
    .clk(clk), .en(en), .x(xh), .den(dh), .q(hue)
  );

  hci_div #(.DW(DW), .QW(FB + 1)) u_div_s (
    .clk(clk), .en(en), .x(xs), .den(ds), .q(sat)
  );

endmodule
`default_nettype wire

// File: design/hci_blend.sv
`timescale 1ns / 1ps
`default_nettype none
module hci_blend #(
  parameter int FB = hci_pkg::FRACTION_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        valid_in,
  input  wire logic [FB:0] h1,
  input  wire logic [FB:0] s1,
  input  wire logic [FB:0] l1,
  input  wire logic [FB:0] h2,
  input  wire logic [FB:0] s2,
  input  wire logic [FB:0] l2,
  input  wire logic [FB:0] pos,
  output logic             valid_out,
  output logic      [FB:0] hue,
  output logic      [FB:0] sat,
  output logic      [FB:0] light
);

  localparam int W = FB + 1;
  localparam logic [W:0] ONE_X = (W + 1)'(1) << FB;

  // first stage: distances and directions
  logic         v1, v2;
  logic [W-1:0] hd_c, ld_c, sd_c;
  logic         hup_c;
  logic [W:0]   cw, ccw;
  logic [W-1:0] hd, ld, sd, h1_1, l1_1, s1_1, pos_1;
  logic         hup, lup, sup;

  always_comb begin
    if (h1 >= h2) begin
      ccw = {1'b0, h1} - {1'b0, h2};
      cw  = ONE_X + {1'b0, h2} - {1'b0, h1};
    end else begin
      ccw = ONE_X + {1'b0, h1} - {1'b0, h2};
      cw  = {1'b0, h2} - {1'b0, h1};
    end
    hup_c = (cw <= ccw);
    hd_c  = hup_c ? W'(cw) : W'(ccw);
    ld_c  = (l2 >= l1) ? l2 - l1 : l1 - l2;
    sd_c  = (s2 >= s1) ? s2 - s1 : s1 - s2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hd    <= hd_c;
      ld    <= ld_c;
      sd    <= sd_c;
      hup   <= hup_c;
      lup   <= (l2 >= l1);
      sup   <= (s2 >= s1);
      h1_1  <= h1;
      l1_1  <= l1;
      s1_1  <= s1;
      pos_1 <= pos;
    end
  end

  // second stage: scale the distances by the position
  logic [2*W-1:0] hp, lp, sp;
  logic [W-1:0]   hm, lm, sm, h1_2, l1_2, s1_2;
  logic           hup_2, lup_2, sup_2;

  assign hp = hd * pos_1;
  assign lp = ld * pos_1;
  assign sp = sd * pos_1;

  always_ff @(posedge clk) begin
    if (en) begin
      hm    <= hp[FB +: W];
      lm    <= lp[FB +: W];
      sm    <= sp[FB +: W];
      hup_2 <= hup;
      lup_2 <= lup;
      sup_2 <= sup;
      h1_2  <= h1_1;
      l1_2  <= l1_1;
      s1_2  <= s1_1;
    end
  end

  // third stage: apply and wrap hue into [0, one]
  logic signed [W+1:0] hr, hw;

  always_comb begin
    if (hup_2) hr = $signed({2'b00, h1_2}) + $signed({2'b00, hm});
    else       hr = $signed({2'b00, h1_2}) - $signed({2'b00, hm});
    if (hr < 0)
      hw = hr + $signed({1'b0, ONE_X});
    else if (hr > $signed({1'b0, ONE_X}))
      hw = hr - $signed({1'b0, ONE_X});
    else
      hw = hr;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue   <= W'(hw);
      light <= lup_2 ? l1_2 + lm : l1_2 - lm;
      sat   <= sup_2 ? s1_2 + sm : s1_2 - sm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      v1        <= valid_in;
      v2        <= v1;
      valid_out <= v2;
    end
  end

endmodule
`default_nettype wire

// File: design/hci_to_rgb.sv
`timescale 1ns / 1ps
`default_nettype none
module hci_to_rgb #(
  parameter int FB = hci_pkg::FRACTION_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          valid_in,
  input  wire logic [FB:0]   hue,
  input  wire logic [FB:0]   sat,
  input  wire logic [FB:0]   light,
  output logic               valid_out,
  output hci_pkg::color_t    color
);

  localparam int W = FB + 1;
  localparam logic [W:0] ONE_X = (W + 1)'(1) << FB;

  typedef enum logic [1:0] {RG_RISE, RG_HIGH, RG_FALL, RG_LOW} region_t;

  logic v4, v5, v6, v7;

  // stage one: l*s
  logic [2*W-1:0] ls;
  logic [W-1:0]   m, h_4, s_4, l_4;

  assign ls = light * sat;

  always_ff @(posedge clk) begin
    if (en) begin
      m   <= ls[FB +: W];
      h_4 <= hue;
      s_4 <= sat;
      l_4 <= light;
    end
  end

  // stage two: q, p and six times the hue
  logic [W:0]   q_c, p_c;
  logic [W-1:0] q_5, p_5, l_5;
  logic [W+1:0] h6_5;
  logic         gray_5;

  always_comb begin
    if ({l_4, 1'b0} < ONE_X) q_c = {1'b0, l_4} + {1'b0, m};
    else                     q_c = {1'b0, l_4} + {1'b0, s_4} - {1'b0, m};
    p_c = {l_4, 1'b0} - q_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_5    <= W'(q_c);
      p_5    <= W'(p_c);
      h6_5   <= (W + 2)'({h_4, 2'b00}) + (W + 2)'({h_4, 1'b0});
      l_5    <= l_4;
      gray_5 <= (s_4 == '0);
    end
  end

  // stage three: wrap each channel's angle and pick its region
  logic signed [W+3:0] off_x, full_x;
  logic signed [W+3:0] t6 [3];
  logic [W+1:0]        u  [3];
  region_t             rg_c [3];
  logic [W-1:0]        w_c  [3];
  region_t             rg_6 [3];
  logic [W-1:0]        w_6  [3];
  logic [W-1:0]        q_6, p_6, diff_6, l_6;
  logic                gray_6;

  always_comb begin
    off_x  = $signed((W + 4)'({ONE_X, 1'b0}));
    full_x = $signed((W + 4)'({ONE_X, 2'b00})) + off_x;
    t6[0] = $signed({2'b00, h6_5}) + off_x;
    t6[1] = $signed({2'b00, h6_5});
    t6[2] = $signed({2'b00, h6_5}) - off_x;
    for (int c = 0; c < 3; c++) begin
      if (t6[c] < 0)           u[c] = (W + 2)'(t6[c] + full_x);
      else if (t6[c] > full_x) u[c] = (W + 2)'(t6[c] - full_x);
      else                     u[c] = (W + 2)'(t6[c]);
      if (u[c] < (W + 2)'(ONE_X)) begin
        rg_c[c] = RG_RISE;
        w_c[c]  = W'(u[c]);
      end else if (u[c] < (W + 2)'(ONE_X) * 3) begin
        rg_c[c] = RG_HIGH;
        w_c[c]  = '0;
      end else if (u[c] < (W + 2)'({ONE_X, 1'b0}) * 2) begin
        rg_c[c] = RG_FALL;
        w_c[c]  = W'((W + 2)'({ONE_X, 1'b0}) * 2 - u[c]);
      end else begin
        rg_c[c] = RG_LOW;
        w_c[c]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        rg_6[c] <= rg_c[c];
        w_6[c]  <= w_c[c];
      end
      q_6    <= q_5;
      p_6    <= p_5;
      diff_6 <= q_5 - p_5;
      l_6    <= l_5;
      gray_6 <= gray_5;
    end
  end

  // stage four: ramp products
  logic [2*W-1:0] pr [3];
  logic [W-1:0]   pm_7 [3];
  region_t        rg_7 [3];
  logic [W-1:0]   q_7, p_7, l_7;
  logic           gray_7;

  always_comb begin
    for (int c = 0; c < 3; c++) pr[c] = diff_6 * w_6[c];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        pm_7[c] <= pr[c][FB +: W];
        rg_7[c] <= rg_6[c];
      end
      q_7    <= q_6;
      p_7    <= p_6;
      l_7    <= l_6;
      gray_7 <= gray_6;
    end
  end

  // stage five: select channel value and scale to a byte
  logic [W-1:0] val [3];
  logic [W+7:0] sc  [3];
  logic [8:0]   bv  [3];
  logic [7:0]   by  [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      unique case (rg_7[c])
        RG_RISE, RG_FALL: val[c] = p_7 + pm_7[c];
        RG_HIGH:          val[c] = q_7;
        RG_LOW:           val[c] = p_7;
        default:          val[c] = p_7;
      endcase
      if (gray_7) val[c] = l_7;
      sc[c] = (W + 8)'({val[c], 8'h00}) - (W + 8)'(val[c]);
      bv[c] = sc[c][FB +: 9];
      by[c] = bv[c][8] ? 8'hFF : bv[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      color.out_red   <= by[0];
      color.out_green <= by[1];
      color.out_blue  <= by[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      v4        <= valid_in;
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      valid_out <= v7;
    end
  end

endmodule
`default_nettype wire

// File: design/hsl_color_interpolator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a result waits in the output register.
// The depth is set by the per-bit restoring dividers of the HSL conversion.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module hsl_color_interpolator_top #(
  parameter int FRACTION_BITS = hci_pkg::FRACTION_BITS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pair_valid,
  output logic                pair_ready,
  input  wire hci_pkg::pair_t pair,
  output logic                color_valid,
  input  wire logic           color_ready,
  output hci_pkg::color_t     color
);

  localparam int FB = FRACTION_BITS;
  localparam int FL = FB + 3;

  logic en;
  assign en         = !color_valid || color_ready;
  assign pair_ready = en;

  // position: clamp, rescale and carry along the conversion
  logic [16:0] pos_c;
  logic [FB:0] pos_s;

  assign pos_c = (pair.position > hci_pkg::POS_FULL) ? hci_pkg::POS_FULL : pair.position;

  if (FB >= 16) begin : g_pos_up
    assign pos_s = (FB + 1)'(pos_c) << (FB - 16);
  end else begin : g_pos_dn
    assign pos_s = (FB + 1)'(pos_c >> (16 - FB));
  end

  logic [FB:0] pos_d [FL];
  logic        v_d   [FL];

  always_ff @(posedge clk) begin
    if (en) begin
      pos_d[0] <= pos_s;
      for (int i = 1; i < FL; i++) pos_d[i] <= pos_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FL; i++) v_d[i] <= 1'b0;
    end else if (en) begin
      v_d[0] <= pair_valid;
      for (int i = 1; i < FL; i++) v_d[i] <= v_d[i-1];
    end
  end

  logic [FB:0] h1, s1, l1, h2, s2, l2;

  hci_to_hsl #(.FB(FB)) u_hsl_start (
    .clk(clk), .en(en),
    .red(pair.start_red), .green(pair.start_green), .blue(pair.start_blue),
    .hue(h1), .sat(s1), .light(l1)
  );

  hci_to_hsl #(.FB(FB)) u_hsl_end (
    .clk(clk), .en(en),
    .red(pair.end_red), .green(pair.end_green), .blue(pair.end_blue),
    .hue(h2), .sat(s2), .light(l2)
  );

  logic        bv;
  logic [FB:0] hb, sb, lb;

  hci_blend #(.FB(FB)) u_blend (
    .clk(clk), .rst(rst), .en(en), .valid_in(v_d[FL-1]),
    .h1(h1), .s1(s1), .l1(l1), .h2(h2), .s2(s2), .l2(l2), .pos(pos_d[FL-1]),
    .valid_out(bv), .hue(hb), .sat(sb), .light(lb)
  );

  hci_to_rgb #(.FB(FB)) u_rgb (
    .clk(clk), .rst(rst), .en(en), .valid_in(bv),
    .hue(hb), .sat(sb), .light(lb),
    .valid_out(color_valid), .color(color)
  );

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int FB = 16;
  localparam longint ONE = 64'd1 << FB;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pair_valid = 1'b0;
  logic pair_ready;
  hci_pkg::pair_t pair = '0;
  logic color_valid;
  logic color_ready = 1'b0;
  hci_pkg::color_t color;

  hsl_color_interpolator_top dut (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_ready(pair_ready), .pair(pair),
    .color_valid(color_valid), .color_ready(color_ready), .color(color)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  hci_pkg::pair_t pending_pairs[$];
  hci_pkg::color_t expected_colors[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_send = 1'b0;
  int errors = 0;
  int checked = 0;

  function automatic void rgb_to_hsl(input longint r, g, b, output longint h, s, l);
    longint hi, lo, d, sum, t;
    hi = r; lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    sum = hi + lo;
    l = (sum * ONE) / 510;
    if (hi == lo) begin
      h = 0;
      s = 0;
    end else begin
      d = hi - lo;
      if (sum > 255) s = (d * ONE) / (510 - sum);
      else s = (d * ONE) / sum;
      if (hi == r) t = (g >= b) ? (g - b) : (6 * d - (b - g));
      else if (hi == g) t = 2 * d + b - r;
      else t = 4 * d + r - g;
      h = (t * ONE) / (6 * d);
    end
  endfunction

  function automatic longint hue_channel(longint p, q, t6);
    longint full;
    full = 6 * ONE;
    if (t6 < 0) t6 += full;
    if (t6 > full) t6 -= full;
    if (t6 < ONE) return p + (((q - p) * t6) >>> FB);
    if (t6 < 3 * ONE) return q;
    if (t6 < 4 * ONE) return p + (((q - p) * (4 * ONE - t6)) >>> FB);
    return p;
  endfunction

  function automatic logic [7:0] frac_to_byte(longint x);
    longint v;
    v = (x * 255) >>> FB;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic longint lerp_frac(longint a, b, pos);
    if (b >= a) return a + (((b - a) * pos) >>> FB);
    return a - (((a - b) * pos) >>> FB);
  endfunction

  function automatic hci_pkg::color_t blend_in_hsl(hci_pkg::pair_t it);
    longint h1, s1, l1, h2, s2, l2, pos, cw, ccw, h, s, l, p, q, r, g, b;
    hci_pkg::color_t c;
    rgb_to_hsl(it.start_red, it.start_green, it.start_blue, h1, s1, l1);
    rgb_to_hsl(it.end_red, it.end_green, it.end_blue, h2, s2, l2);
    pos = it.position;
    if (pos > 65536) pos = 65536;
    pos = (pos * ONE) / 65536;
    if (h1 >= h2) begin
      ccw = h1 - h2;
      cw = ONE + h2 - h1;
    end else begin
      ccw = ONE + h1 - h2;
      cw = h2 - h1;
    end
    if (cw <= ccw) h = h1 + ((cw * pos) >>> FB);
    else h = h1 - ((ccw * pos) >>> FB);
    if (h < 0) h += ONE;
    if (h > ONE) h -= ONE;
    l = lerp_frac(l1, l2, pos);
    s = lerp_frac(s1, s2, pos);
    if (s == 0) begin
      r = l; g = l; b = l;
    end else begin
      if (2 * l < ONE) q = (l * (ONE + s)) >>> FB;
      else q = l + s - ((l * s) >>> FB);
      p = 2 * l - q;
      r = hue_channel(p, q, 6 * h + 2 * ONE);
      g = hue_channel(p, q, 6 * h);
      b = hue_channel(p, q, 6 * h - 2 * ONE);
    end
    c.out_red = frac_to_byte(r);
    c.out_green = frac_to_byte(g);
    c.out_blue = frac_to_byte(b);
    return c;
  endfunction

  // driver: keep valid up until accepted, then present the next item
  always @(posedge clk) begin
    if (!rst) begin
      if (pair_valid && pair_ready) begin
        expected_colors.push_back(blend_in_hsl(pair));
      end
      if (!pair_valid || pair_ready) begin
        if (pending_pairs.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          pair <= pending_pairs.pop_front();
          pair_valid <= 1'b1;
        end else begin
          pair_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    hci_pkg::color_t exp_c;
    if (!rst) begin
      if (color_valid && color_ready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected item %h", $time, color);
          errors++;
        end else begin
          exp_c = expected_colors.pop_front();
          checked++;
          if (exp_c.out_red !== color.out_red)
            $display("%0t: red exp %0d got %0d", $time, exp_c.out_red, color.out_red);
          if (exp_c.out_green !== color.out_green)
            $display("%0t: green exp %0d got %0d", $time, exp_c.out_green,
                     color.out_green);
          if (exp_c.out_blue !== color.out_blue)
            $display("%0t: blue exp %0d got %0d", $time, exp_c.out_blue, color.out_blue);
          if (exp_c !== color) errors++;
        end
      end
      color_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic hci_pkg::pair_t rand_pair();
    hci_pkg::pair_t it;
    it = hci_pkg::pair_t'({$urandom, $urandom});
    case ($urandom_range(9))
      0: it.position = 17'd65536 + $urandom_range(65535);
      1: it.position = 17'd65536;
      2: it.position = 17'd0;
      3: begin
        it.start_green = it.start_red;
        it.start_blue = it.start_red;
      end
      4: begin
        it.end_green = it.end_red;
        it.end_blue = it.end_red;
      end
      default: it.position = $urandom_range(65536);
    endcase
    return it;
  endfunction

  task automatic add_pair(input logic [7:0] a, b, c, d, e, f, input logic [16:0] pos);
    hci_pkg::pair_t it;
    it = '{a, b, c, d, e, f, pos};
    pending_pairs.push_back(it);
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || pair_valid) @(posedge clk);
    while (expected_colors.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // extremes, gray colors, hue wrap and tied shorter ways
    add_pair(0, 0, 0, 255, 255, 255, 0);
    add_pair(0, 0, 0, 255, 255, 255, 65536);
    add_pair(0, 0, 0, 255, 255, 255, 32768);
    add_pair(255, 0, 0, 0, 0, 255, 32768);
    add_pair(255, 0, 0, 0, 255, 255, 32768);
    add_pair(0, 255, 255, 255, 0, 0, 32768);
    add_pair(255, 0, 0, 255, 0, 255, 40000);
    add_pair(255, 0, 255, 255, 0, 0, 40000);
    add_pair(255, 0, 0, 0, 255, 0, 131071);
    add_pair(128, 128, 128, 128, 128, 128, 12345);
    add_pair(255, 255, 0, 0, 255, 255, 65535);
    add_pair(1, 0, 0, 255, 254, 255, 1);
    add_pair(10, 200, 30, 250, 5, 100, 100000);
    add_pair(255, 255, 255, 0, 0, 1, 20000);
    add_pair(200, 100, 50, 200, 100, 50, 50000);
    add_pair(0, 0, 255, 255, 255, 0, 32768);
    drain();
    send_idle_pct = 18; recv_idle_pct = 49;
    repeat (350) pending_pairs.push_back(rand_pair());
    drain();
    send_idle_pct = 49; recv_idle_pct = 18;
    repeat (350) pending_pairs.push_back(rand_pair());
    // stop sending mid-stream until every result is out, then resume
    repeat (150) @(posedge clk);
    hold_send = 1'b1;
    while (pair_valid || expected_colors.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    hold_send = 1'b0;
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (350) pending_pairs.push_back(rand_pair());
    drain();
    repeat (60) @(posedge clk);
    $display("covered %0d blends: directed extremes plus random colors under", checked);
    $display("three idle mixes, including gray, saturated and wrapped positions");
    if (errors == 0 && expected_colors.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end
endmodule
